### design/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bpc_pkg;

    // Number of register stages from input beat to output register.
    localparam int unsigned STAGES = 9;

    // Width of the offset and sensitivity terms and their corrections.
    localparam int unsigned OFF_W = 40;

    // Calibration register indexes on the configuration port.
    typedef enum logic [2:0] {
        CFG_PSENS    = 3'd0,
        CFG_POFF     = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5
    } cfg_idx_t;

    // 20.00 C, the corner of the second-order correction.
    localparam logic signed [18:0] TEMP_REF = 19'sd2000;
    // Distance from 20.00 C down to -15.00 C.
    localparam logic signed [18:0] TEMP_LOW_SPAN = 19'sd3500;

    // Stage enables and occupancy, handed from the pipeline control to the datapath.
    typedef struct packed {
        logic [STAGES-1:0] en;
        logic [STAGES-1:0] vld;
    } pipe_ctl_t;

endpackage

### design/baro_pressure_temp_compensation.sv
// Top level: barometric pressure and temperature compensation pipeline.
//
// Takes one raw pressure and one raw temperature conversion per beat and,
// with the six calibration words, returns temperature in 0.01 C and
// pressure in 0.01 mbar, including the second-order correction below
// 20 C and the extra term below -15 C. The datapath is a nine-stage
// pipeline: one beat enters per clock while in_ready is high, and each
// beat passes through stages 0 to 8 in order, stage 8 being the output
// register that drives out_valid. The depth is set by the chain of
// multiplications (raw products, squares of the temperature error, and
// the pressure product split in two halves). The output register and
// per-stage valid bits let new beats keep entering while a result waits;
// a stall fills the empty stages and then holds the input. Calibration
// words are written through cfg_wen/cfg_addr/cfg_wdata at any edge, take
// effect in the stages that read them, also for beats already in flight,
// and should only change while the pipeline is empty. Writes to indexes
// six and seven are ignored.
module baro_pressure_temp_compensation (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_wen,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [23:0]        pressure_raw,
    input  logic [23:0]        temperature_raw,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [18:0] temperature_centi,
    output logic signed [31:0] pressure_centi
);

    localparam int unsigned W = bpc_pkg::OFF_W;

    bpc_pkg::pipe_ctl_t ctl;

    // Calibration words
    logic [15:0] psens_reg;
    logic [15:0] poff_reg;
    logic [15:0] tcs_reg;
    logic [15:0] tco_reg;
    logic [15:0] tref_reg;
    logic [15:0] tempsens_reg;

    // Stage 0: temperature difference dT
    logic [23:0]        s0_d1_reg;
    logic signed [24:0] s0_dt_reg;
    logic signed [24:0] s0_dt_next;

    // Stage 1: raw products
    logic [23:0]        s1_d1_reg;
    logic signed [41:0] s1_pt_reg, s1_pt_next;
    logic signed [41:0] s1_po_reg, s1_po_next;
    logic signed [41:0] s1_ps_reg, s1_ps_next;
    logic signed [49:0] s1_pq_reg, s1_pq_next;

    // Stage 2: first-order terms
    logic [23:0]        s2_d1_reg;
    logic signed [17:0] s2_d_reg, s2_d_next;
    logic signed [W-1:0] s2_off_reg, s2_off_next;
    logic signed [W-1:0] s2_sens_reg, s2_sens_next;
    logic [17:0]        s2_t2_reg, s2_t2_next;
    logic signed [41:0] sh_t;
    logic signed [41:0] sh_o;
    logic signed [41:0] sh_s;

    // Stage 3: squares of the temperature error
    logic [23:0]        s3_d1_reg;
    logic signed [18:0] s3_temp_reg, s3_temp_next;
    logic [35:0]        s3_dd_reg, s3_dd_next;
    logic [35:0]        s3_ee_reg, s3_ee_next;
    logic               s3_lt_reg, s3_lt_next;
    logic               s3_lm_reg, s3_lm_next;
    logic signed [W-1:0] s3_off_reg;
    logic signed [W-1:0] s3_sens_reg;
    logic [17:0]        s3_t2_reg;
    logic signed [18:0] e_c;
    logic signed [37:0] dd_full;
    logic signed [37:0] ee_full;

    // Stage 4: second-order corrections
    logic [23:0]        s4_d1_reg;
    logic signed [18:0] s4_temp_reg, s4_temp_next;
    logic signed [W-1:0] s4_off_reg;
    logic signed [W-1:0] s4_sens_reg;
    logic [W-1:0]       s4_off2_reg, s4_off2_next;
    logic [W-1:0]       s4_sens2_reg, s4_sens2_next;
    logic [W-1:0]       dd5;
    logic [W-1:0]       ee7;
    logic [W-1:0]       ee11;

    // Stage 5: corrected OFF and SENS
    logic [23:0]        s5_d1_reg;
    logic signed [18:0] s5_temp_reg;
    logic signed [W-1:0] s5_off_reg, s5_off_next;
    logic signed [W-1:0] s5_sens_reg, s5_sens_next;

    // Stage 6: D1*SENS as two partial products
    logic signed [18:0] s6_temp_reg;
    logic signed [W-1:0] s6_off_reg;
    logic [43:0]        s6_pplo_reg, s6_pplo_next;
    logic signed [44:0] s6_pphi_reg, s6_pphi_next;

    // Stage 7: full product
    logic signed [18:0] s7_temp_reg;
    logic signed [W-1:0] s7_off_reg;
    logic signed [63:0] s7_x_reg, s7_x_next;

    // Stage 8: output register
    logic signed [18:0] s8_temp_reg;
    logic signed [31:0] s8_p_reg, s8_p_next;
    logic signed [63:0] xs;
    logic signed [63:0] pf;
    logic signed [63:0] pw;

    bpc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    assign in_ready  = ctl.en[0];
    assign out_valid = ctl.vld[bpc_pkg::STAGES-1];

    // Calibration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psens_reg    <= '0;
            poff_reg     <= '0;
            tcs_reg      <= '0;
            tco_reg      <= '0;
            tref_reg     <= '0;
            tempsens_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (bpc_pkg::cfg_idx_t'(cfg_addr))
                bpc_pkg::CFG_PSENS:    psens_reg    <= cfg_wdata;
                bpc_pkg::CFG_POFF:     poff_reg     <= cfg_wdata;
                bpc_pkg::CFG_TCS:      tcs_reg      <= cfg_wdata;
                bpc_pkg::CFG_TCO:      tco_reg      <= cfg_wdata;
                bpc_pkg::CFG_TREF:     tref_reg     <= cfg_wdata;
                bpc_pkg::CFG_TEMPSENS: tempsens_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // dT = D2 - C5*256
        s0_dt_next = $signed({1'b0, temperature_raw}) - $signed({1'b0, tref_reg, 8'h00});

        // products with dT
        s1_pt_next = s0_dt_reg * $signed({1'b0, tempsens_reg});
        s1_po_next = s0_dt_reg * $signed({1'b0, tco_reg});
        s1_ps_next = s0_dt_reg * $signed({1'b0, tcs_reg});
        s1_pq_next = s0_dt_reg * s0_dt_reg;

        // d = TEMP - 2000 is the shifted temperature product itself
        sh_t         = s1_pt_reg >>> 23;
        sh_o         = s1_po_reg >>> 7;
        sh_s         = s1_ps_reg >>> 8;
        s2_d_next    = sh_t[17:0];
        s2_off_next  = $signed({8'd0, poff_reg, 16'd0}) + $signed(sh_o[W-1:0]);
        s2_sens_next = $signed({9'd0, psens_reg, 15'd0}) + $signed(sh_s[W-1:0]);
        s2_t2_next   = s1_pq_reg[48:31];

        // e = TEMP + 1500
        e_c          = s2_d_reg + bpc_pkg::TEMP_LOW_SPAN;
        dd_full      = s2_d_reg * s2_d_reg;
        ee_full      = e_c * e_c;
        s3_dd_next   = dd_full[35:0];
        s3_ee_next   = ee_full[35:0];
        s3_temp_next = s2_d_reg + bpc_pkg::TEMP_REF;
        s3_lt_next   = s2_d_reg[17];
        s3_lm_next   = e_c[18];

        // 5*d*d, 7*e*e, 11*e*e by shift and add; all non-negative
        dd5  = {4'd0, s3_dd_reg} + {2'd0, s3_dd_reg, 2'b00};
        ee7  = {1'b0, s3_ee_reg, 3'b000} - {4'd0, s3_ee_reg};
        ee11 = {1'b0, s3_ee_reg, 3'b000} + {3'd0, s3_ee_reg, 1'b0} + {4'd0, s3_ee_reg};
        if (s3_lt_reg)
        begin
            s4_off2_next  = (dd5 >> 1) + (s3_lm_reg ? ee7 : '0);
            s4_sens2_next = (dd5 >> 2) + (s3_lm_reg ? (ee11 >> 1) : '0);
            s4_temp_next  = s3_temp_reg - $signed({1'b0, s3_t2_reg});
        end
        else
        begin
            s4_off2_next  = '0;
            s4_sens2_next = '0;
            s4_temp_next  = s3_temp_reg;
        end

        s5_off_next  = s4_off_reg - $signed(s4_off2_reg);
        s5_sens_next = s4_sens_reg - $signed(s4_sens2_reg);

        // SENS = hi*2^20 + lo, lo unsigned
        s6_pplo_next = s5_d1_reg * s5_sens_reg[19:0];
        s6_pphi_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[W-1:20]);

        s7_x_next = (64'(s6_pphi_reg) <<< 20) + $signed({20'd0, s6_pplo_reg});

        xs        = s7_x_reg >>> 21;
        pf        = xs - 64'(s7_off_reg);
        pw        = pf >>> 15;
        s8_p_next = pw[31:0];
    end

    // Pipeline payload; each stage loads with its own enable
    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            s0_d1_reg <= pressure_raw;
            s0_dt_reg <= s0_dt_next;
        end
        if (ctl.en[1])
        begin
            s1_d1_reg <= s0_d1_reg;
            s1_pt_reg <= s1_pt_next;
            s1_po_reg <= s1_po_next;
            s1_ps_reg <= s1_ps_next;
            s1_pq_reg <= s1_pq_next;
        end
        if (ctl.en[2])
        begin
            s2_d1_reg   <= s1_d1_reg;
            s2_d_reg    <= s2_d_next;
            s2_off_reg  <= s2_off_next;
            s2_sens_reg <= s2_sens_next;
            s2_t2_reg   <= s2_t2_next;
        end
        if (ctl.en[3])
        begin
            s3_d1_reg   <= s2_d1_reg;
            s3_temp_reg <= s3_temp_next;
            s3_dd_reg   <= s3_dd_next;
            s3_ee_reg   <= s3_ee_next;
            s3_lt_reg   <= s3_lt_next;
            s3_lm_reg   <= s3_lm_next;
            s3_off_reg  <= s2_off_reg;
            s3_sens_reg <= s2_sens_reg;
            s3_t2_reg   <= s2_t2_reg;
        end
        if (ctl.en[4])
        begin
            s4_d1_reg    <= s3_d1_reg;
            s4_temp_reg  <= s4_temp_next;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_off2_reg  <= s4_off2_next;
            s4_sens2_reg <= s4_sens2_next;
        end
        if (ctl.en[5])
        begin
            s5_d1_reg   <= s4_d1_reg;
            s5_temp_reg <= s4_temp_reg;
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
        end
        if (ctl.en[6])
        begin
            s6_temp_reg <= s5_temp_reg;
            s6_off_reg  <= s5_off_reg;
            s6_pplo_reg <= s6_pplo_next;
            s6_pphi_reg <= s6_pphi_next;
        end
        if (ctl.en[7])
        begin
            s7_temp_reg <= s6_temp_reg;
            s7_off_reg  <= s6_off_reg;
            s7_x_reg    <= s7_x_next;
        end
        if (ctl.en[8])
        begin
            s8_temp_reg <= s7_temp_reg;
            s8_p_reg    <= s8_p_next;
        end
    end

    assign temperature_centi = s8_temp_reg;
    assign pressure_centi    = s8_p_reg;

`ifndef SYNTH
    // Below -15 C is only reachable from below 20 C.
    a_low_implies_cold: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.vld[3] && s3_lm_reg |-> s3_lt_reg)
        else $error("extra low-temperature term without second-order flag");

    // dT*dT >> 31 stays below 2^17 for any 24-bit inputs.
    a_t2_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.vld[2] |-> !s2_t2_reg[17])
        else $error("T2 out of range");

    // Second-order corrections are non-negative and never reach the sign bit.
    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.vld[4] |-> !s4_off2_reg[W-1] && !s4_sens2_reg[W-1])
        else $error("second-order correction overflow");
`endif

endmodule

### design/bpc_pipe_ctrl.sv
// Valid bits and per-stage load enables for the compensation pipeline.
module bpc_pipe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    output bpc_pkg::pipe_ctl_t  ctl
);

    localparam int unsigned S = bpc_pkg::STAGES;

    logic [S-1:0] vld_reg;
    logic [S-1:0] vld_next;
    logic [S-1:0] en;
    logic [S-1:0] vld_in;

    // A stage loads when it is empty or when the stage after it loads too,
    // so bubbles close up behind a stalled output.
    always_comb
    begin
        en[S-1] = !vld_reg[S-1] || out_ready;
        for (int k = S - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_in   = {vld_reg[S-2:0], in_valid};
        vld_next = (en & vld_in) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctl.en  = en;
    assign ctl.vld = vld_reg;

`ifndef SYNTH
    // Input held off only when every stage holds a beat.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !en[0] |-> (&vld_reg))
        else $error("input blocked with an empty stage");

    // A beat leaving stage 0 into a loading stage 1 arrives there.
    a_moves_forward: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && en[1] |=> vld_reg[1])
        else $error("beat lost between stage 0 and stage 1");

    // An accepted input beat occupies stage 0 on the next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && en[0] |=> vld_reg[0])
        else $error("accepted beat missing from stage 0");
`endif

endmodule
